/* rtl/pfa_pkg.sv */
// Shared types and constants of the page frame allocator.
`default_nettype none

package pfa_pkg;

  // Operation codes
  localparam logic [1:0] OP_PAGE_IN = 2'd0;
  localparam logic [1:0] OP_EVICT   = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_NO_FREE   = 2'd2;
  localparam logic [1:0] STAT_BAD       = 2'd3;

  // Owner character of a free frame ('.')
  localparam logic [7:0] DOT_CHAR = 8'd46;

  // Field width of the page number on the request
  localparam int PAGE_FIELD_W = 10;

  typedef struct packed {
    logic [1:0]              operation;
    logic [PAGE_FIELD_W-1:0] page;
    logic [7:0]              owner;
    logic [6:0]              victim_frame;
  } pfa_req_t;

  typedef struct packed {
    logic [6:0] frame;
    logic [1:0] status;
    logic [7:0] found_owner;
    logic [7:0] free_count;
  } pfa_rsp_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN
  } pfa_state_t;

endpackage

`default_nettype wire

/* rtl/page_frame_allocator.sv */
// Page frame allocator: FIFO free list and frame table held in synchronous RAMs.
//
//   channel   ports                     transfer
//   request   start, busy, request      edge with start high and busy low
//   result    done, result              edge ending the cycle with done high
//
// page_in, evict and unknown codes: the S_EXEC state (free ring read, then table write),
// then the registered result; busy holds off the next request until then.
// lookup: one table entry per cycle through the table RAM read port until a hit
// or the last frame, then the registered result.
// After reset a clearing pass over every frame fills both RAMs; busy is high.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module page_frame_allocator #(
  parameter int FRAMES    = 128,
  parameter int PAGE_BITS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire pfa_pkg::pfa_req_t request,
  output logic                   done,
  output pfa_pkg::pfa_rsp_t      result
);

  import pfa_pkg::*;

  localparam int FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int TW  = $clog2(FRAMES + 1);
  localparam int PW  = (PAGE_BITS < PAGE_FIELD_W) ? PAGE_BITS : PAGE_FIELD_W;
  // table entry: used, owner, page
  localparam int TBW = 1 + 8 + PW;
  localparam logic [FW-1:0] LAST_FRAME = FW'(FRAMES - 1);

  // Memories
  logic [FW-1:0]  ring_mem [FRAMES];
  logic [TBW-1:0] tbl_mem  [FRAMES];

  logic           ring_we;
  logic [FW-1:0]  ring_waddr, ring_wdata, ring_rdata;
  logic           tbl_we;
  logic [FW-1:0]  tbl_waddr, tbl_raddr;
  logic [TBW-1:0] tbl_wdata, tbl_rdata;

  // Control and payload registers
  pfa_state_t     state, state_next;
  logic [FW-1:0]  head, head_next;
  logic [FW-1:0]  tail, tail_next;
  logic [TW-1:0]  free_total, free_total_next;
  logic [FW-1:0]  clear_addr, clear_addr_next;
  logic [FW-1:0]  scan_addr, scan_addr_next;
  pfa_req_t       req_q;
  pfa_rsp_t       rsp_next;
  logic           done_next;

  // Decoded table read data and request
  logic           tbl_used;
  logic [7:0]     tbl_owner;
  logic [PW-1:0]  tbl_page;
  logic [PW-1:0]  page_key;
  logic [FW-1:0]  victim_idx;
  logic [FW-1:0]  in_victim_idx;
  logic           victim_ok;
  logic           scan_hit;
  logic           accept;

  assign tbl_used      = tbl_rdata[TBW-1];
  assign tbl_owner     = tbl_rdata[PW +: 8];
  assign tbl_page      = tbl_rdata[PW-1:0];
  assign page_key      = PW'(req_q.page);
  assign victim_idx    = FW'(req_q.victim_frame);
  assign in_victim_idx = FW'(request.victim_frame);
  assign victim_ok     = 32'(req_q.victim_frame) < 32'(FRAMES);
  assign scan_hit      = tbl_used && (tbl_page == page_key);
  assign busy          = (state != S_IDLE);
  assign accept        = start && !busy;

  // Free ring RAM
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    ring_rdata <= ring_mem[head];
  end

  // Frame table RAM
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata <= tbl_mem[tbl_raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clear_addr == LAST_FRAME) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          state_next = (request.operation == OP_LOOKUP) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: state_next = S_IDLE;
      S_SCAN: if (scan_hit || scan_addr == LAST_FRAME) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    ring_we         = 1'b0;
    ring_waddr      = tail;
    ring_wdata      = victim_idx;
    tbl_we          = 1'b0;
    tbl_waddr       = victim_idx;
    tbl_wdata       = {1'b0, DOT_CHAR, PW'(0)};
    tbl_raddr       = (request.operation == OP_LOOKUP) ? '0 : in_victim_idx;
    head_next       = head;
    tail_next       = tail;
    free_total_next = free_total;
    clear_addr_next = clear_addr;
    scan_addr_next  = scan_addr;
    done_next       = 1'b0;
    rsp_next        = '{frame: 7'd0, status: STAT_OK, found_owner: DOT_CHAR,
                        free_count: 8'(free_total)};
    unique case (state)
      // fill ring with 0..FRAMES-1 and mark all frames free
      S_CLEAR: begin
        ring_we         = 1'b1;
        ring_waddr      = clear_addr;
        ring_wdata      = clear_addr;
        tbl_we          = 1'b1;
        tbl_waddr       = clear_addr;
        clear_addr_next = FW'(clear_addr + 1'b1);
      end
      S_IDLE: begin
        if (accept) scan_addr_next = '0;
      end
      S_EXEC: begin
        done_next = 1'b1;
        case (req_q.operation)
          OP_PAGE_IN: begin
            if (free_total == '0) begin
              rsp_next.status = STAT_NO_FREE;
            end else begin
              tbl_we          = 1'b1;
              tbl_waddr       = ring_rdata;
              tbl_wdata       = {1'b1, req_q.owner, page_key};
              head_next       = (head == LAST_FRAME) ? '0 : FW'(head + 1'b1);
              free_total_next = TW'(free_total - 1'b1);
              rsp_next.frame  = 7'(ring_rdata);
            end
          end
          OP_EVICT: begin
            rsp_next.frame = req_q.victim_frame;
            if (!victim_ok || !tbl_used) begin
              rsp_next.status = STAT_BAD;
            end else begin
              tbl_we          = 1'b1;
              ring_we         = 1'b1;
              tail_next       = (tail == LAST_FRAME) ? '0 : FW'(tail + 1'b1);
              free_total_next = TW'(free_total + 1'b1);
            end
          end
          default: rsp_next.status = STAT_BAD;
        endcase
        rsp_next.free_count = 8'(free_total_next);
      end
      // walk the table, lowest frame first
      S_SCAN: begin
        tbl_raddr = FW'(scan_addr + 1'b1);
        if (scan_hit) begin
          done_next            = 1'b1;
          rsp_next.frame       = 7'(scan_addr);
          rsp_next.found_owner = tbl_owner;
        end else if (scan_addr == LAST_FRAME) begin
          done_next       = 1'b1;
          rsp_next.status = STAT_NOT_FOUND;
        end else begin
          scan_addr_next = FW'(scan_addr + 1'b1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      head       <= '0;
      tail       <= '0;
      free_total <= TW'(FRAMES);
      clear_addr <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      free_total <= free_total_next;
      clear_addr <= clear_addr_next;
      done       <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) req_q <= request;
    scan_addr <= scan_addr_next;
    if (done_next) result <= rsp_next;
  end

endmodule

`default_nettype wire

/* rtl/pfa_checker.sv */
// Port-level checks of the page frame allocator, bound to the top level.
`default_nettype none

module pfa_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire pfa_pkg::pfa_rsp_t result
);

  import pfa_pkg::*;

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  // a transfer always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after transfer");

  // results never come on back-to-back cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in a row");

  // no free frame only when the count is zero
  a_no_free: assert property (@(posedge clk) disable iff (rst)
    done && result.status == STAT_NO_FREE |-> result.free_count == 8'd0)
    else $error("no-free status with free frames");

  // an owner is reported only on a successful request
  a_owner_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.found_owner != DOT_CHAR |-> result.status == STAT_OK)
    else $error("owner reported on a failed request");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

/* dv/page_frame_allocator_tb.sv */
// Self-checking testbench for the page frame allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module page_frame_allocator_tb;
  import pfa_pkg::*;

  localparam int FRAMES       = 128;
  localparam int PAGE_BITS    = 10;
  localparam int RANDOM_ITEMS = 1900;
  localparam int MAX_REPORTS  = 10;
  localparam int REQ_W        = $bits(pfa_req_t);
  // code 3 is not an operation; the block must answer it with a bad status
  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam logic [PAGE_FIELD_W-1:0] PAGE_MASK = PAGE_FIELD_W'((1 << PAGE_BITS) - 1);

  // traffic mixes for the random part
  localparam int MIX_FILL  = 0;
  localparam int MIX_DRAIN = 1;
  localparam int MIX_BLEND = 2;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  pfa_req_t request = '0;
  logic     busy;
  logic     done;
  pfa_rsp_t result;

  page_frame_allocator #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #4 clk = ~clk;

  // Shadow copy of the allocator state
  logic [6:0]              ring_frames [FRAMES];
  int                      ring_rd;
  int                      ring_wr;
  int                      frames_free;
  logic [PAGE_FIELD_W-1:0] held_page   [FRAMES];
  logic [7:0]              held_owner  [FRAMES];
  bit                      in_use      [FRAMES];

  pfa_rsp_t due_responses[$];
  int       mismatch_total = 0;

  // typed expectation for the request currently on offer (directed rows only)
  bit       row_typed = 1'b0;
  pfa_rsp_t row_answer;

  initial begin
    for (int i = 0; i < FRAMES; i++) begin
      ring_frames[i] = i[6:0];
      held_page[i]   = '0;
      held_owner[i]  = DOT_CHAR;
      in_use[i]      = 1'b0;
    end
    ring_rd     = 0;
    ring_wr     = 0;
    frames_free = FRAMES;
  end

  // Apply one request to the shadow state and return the answer it earns
  function automatic pfa_rsp_t predict_frame_op(input pfa_req_t rq);
    pfa_rsp_t                r;
    logic [PAGE_FIELD_W-1:0] pg;
    logic [6:0]              f;
    bit                      hit;
    r.frame       = '0;
    r.status      = STAT_OK;
    r.found_owner = DOT_CHAR;
    pg            = rq.page & PAGE_MASK;
    hit           = 1'b0;
    case (rq.operation)
      OP_PAGE_IN: begin
        if (frames_free == 0) begin
          r.status = STAT_NO_FREE;
        end else begin
          f           = ring_frames[ring_rd];
          ring_rd     = (ring_rd == FRAMES - 1) ? 0 : ring_rd + 1;
          frames_free = frames_free - 1;
          held_page[f]  = pg;
          held_owner[f] = rq.owner;
          in_use[f]     = 1'b1;
          r.frame       = f;
        end
      end
      OP_EVICT: begin
        r.frame = rq.victim_frame;
        if (int'(rq.victim_frame) >= FRAMES || !in_use[rq.victim_frame]) begin
          r.status = STAT_BAD;
        end else begin
          in_use[rq.victim_frame]     = 1'b0;
          held_owner[rq.victim_frame] = DOT_CHAR;
          held_page[rq.victim_frame]  = '0;
          ring_frames[ring_wr]        = rq.victim_frame;
          ring_wr     = (ring_wr == FRAMES - 1) ? 0 : ring_wr + 1;
          frames_free = frames_free + 1;
        end
      end
      OP_LOOKUP: begin
        // lowest-numbered frame in use wins
        for (int i = 0; i < FRAMES; i++) begin
          if (!hit && in_use[i] && held_page[i] == pg) begin
            hit           = 1'b1;
            r.frame       = i[6:0];
            r.found_owner = held_owner[i];
          end
        end
        if (!hit) r.status = STAT_NOT_FOUND;
      end
      default: begin
        r.status = STAT_BAD;
      end
    endcase
    r.free_count = frames_free[7:0];
    return r;
  endfunction

  // Any frame currently in use, or -1 when all are free
  function automatic int pick_used_frame();
    int base;
    int f;
    base = $urandom_range(0, FRAMES - 1);
    for (int i = 0; i < FRAMES; i++) begin
      f = (base + i) % FRAMES;
      if (in_use[f]) return f;
    end
    return -1;
  endfunction

  // Random request shaped by the current traffic mix and the shadow state
  function automatic pfa_req_t draw_request(input int mix);
    pfa_req_t rq;
    int       roll;
    int       fr;
    int       p_in;
    int       p_ev;
    rq.operation    = OP_LOOKUP;
    rq.page         = PAGE_FIELD_W'($urandom);
    rq.owner        = 8'($urandom);
    rq.victim_frame = 7'($urandom);
    roll = $urandom_range(0, 99);
    // noise: undefined codes and blind evictions
    if (roll < 8) begin
      rq.operation = (roll < 4) ? OP_UNDEF : OP_EVICT;
      return rq;
    end
    case (mix)
      MIX_FILL:  begin p_in = 75; p_ev = 10; end
      MIX_DRAIN: begin p_in = 10; p_ev = 75; end
      default:   begin p_in = 35; p_ev = 35; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < p_in) begin
      rq.operation = OP_PAGE_IN;
      // a small pool of pages makes duplicate mappings common
      if ($urandom_range(0, 1)) rq.page = PAGE_FIELD_W'($urandom_range(0, 15));
    end else if (roll < p_in + p_ev) begin
      rq.operation = OP_EVICT;
      fr = pick_used_frame();
      if (fr >= 0 && $urandom_range(0, 9) != 0) rq.victim_frame = fr[6:0];
    end else begin
      rq.operation = OP_LOOKUP;
      roll = $urandom_range(0, 9);
      fr   = pick_used_frame();
      if (roll < 6 && fr >= 0) rq.page = held_page[fr];
      else if (roll < 8) rq.page = PAGE_FIELD_W'($urandom_range(0, 15));
    end
    return rq;
  endfunction

  function automatic pfa_req_t make_req(input logic [1:0] op, input int pg,
                                        input int own, input int vic);
    pfa_req_t rq;
    rq.operation    = op;
    rq.page         = pg[PAGE_FIELD_W-1:0];
    rq.owner        = own[7:0];
    rq.victim_frame = vic[6:0];
    return rq;
  endfunction

  function automatic pfa_rsp_t make_rsp(input int fr, input logic [1:0] st,
                                        input int own, input int cnt);
    pfa_rsp_t r;
    r.frame       = fr[6:0];
    r.status      = st;
    r.found_owner = own[7:0];
    r.free_count  = cnt[7:0];
    return r;
  endfunction

  // Result checking, then request transfer bookkeeping, at each rising edge
  always @(posedge clk) begin : result_check
    pfa_rsp_t want;
    pfa_rsp_t pred;
    if (!rst && done) begin
      if (due_responses.size() == 0) begin
        mismatch_total++;
        if (mismatch_total <= MAX_REPORTS)
          $display("%0t: result with none outstanding: frame %0d status %0d owner %0d free %0d",
                   $realtime, result.frame, result.status, result.found_owner,
                   result.free_count);
      end else begin
        want = due_responses.pop_front();
        if (result.frame !== want.frame || result.status !== want.status ||
            result.found_owner !== want.found_owner ||
            result.free_count !== want.free_count) begin
          mismatch_total++;
          if (mismatch_total <= MAX_REPORTS)
            $display("%0t: exp frame %0d st %0d own %0d free %0d, got %0d %0d %0d %0d",
                     $realtime, want.frame, want.status, want.found_owner,
                     want.free_count, result.frame, result.status,
                     result.found_owner, result.free_count);
        end
      end
    end
    if (!rst && start && !busy) begin
      pred = predict_frame_op(request);
      due_responses.push_back(row_typed ? row_answer : pred);
    end
  end

  // Offer a request from a falling edge; returns at the falling edge after the transfer
  task automatic send_request(input pfa_req_t rq);
    start   <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start   <= 1'b0;
    request <= pfa_req_t'(REQ_W'($urandom));
    repeat (cycles) @(negedge clk);
  endtask

  typedef struct {
    pfa_req_t req;
    bit       typed;
    pfa_rsp_t answer;
  } table_row_t;

  // Stimulus
  initial begin : stimulus
    table_row_t rows[$];
    table_row_t row;
    int         sent;
    int         seg_len;
    int         mix;
    bit         gappy;
    int         waited;

    // directed table: typed answers only where obvious, the rest predicted
    row.typed = 1'b1;
    row.req = make_req(OP_LOOKUP, 0, 0, 0);
    row.answer = make_rsp(0, STAT_NOT_FOUND, DOT_CHAR, 128);      rows.push_back(row);
    row.req = make_req(OP_EVICT, 0, 0, 0);
    row.answer = make_rsp(0, STAT_BAD, DOT_CHAR, 128);            rows.push_back(row);
    row.req = make_req(OP_EVICT, 1023, 255, 127);
    row.answer = make_rsp(127, STAT_BAD, DOT_CHAR, 128);          rows.push_back(row);
    row.req = make_req(OP_UNDEF, 1023, 255, 127);
    row.answer = make_rsp(0, STAT_BAD, DOT_CHAR, 128);            rows.push_back(row);
    row.req = make_req(OP_PAGE_IN, 1023, 255, 127);
    row.answer = make_rsp(0, STAT_OK, DOT_CHAR, 127);             rows.push_back(row);
    row.req = make_req(OP_PAGE_IN, 0, 0, 0);
    row.answer = make_rsp(1, STAT_OK, DOT_CHAR, 126);             rows.push_back(row);
    row.req = make_req(OP_PAGE_IN, 1023, 8'h41, 0);
    row.answer = make_rsp(2, STAT_OK, DOT_CHAR, 125);             rows.push_back(row);
    row.req = make_req(OP_LOOKUP, 1023, 0, 0);
    row.answer = make_rsp(0, STAT_OK, 255, 125);                  rows.push_back(row);
    row.req = make_req(OP_LOOKUP, 0, 255, 127);
    row.answer = make_rsp(1, STAT_OK, 0, 125);                    rows.push_back(row);
    row.req = make_req(OP_EVICT, 0, 0, 0);
    row.answer = make_rsp(0, STAT_OK, DOT_CHAR, 126);             rows.push_back(row);
    row.req = make_req(OP_EVICT, 0, 0, 0);
    row.answer = make_rsp(0, STAT_BAD, DOT_CHAR, 126);            rows.push_back(row);
    row.typed = 1'b0;
    // duplicate page: the next lowest frame takes over
    row.req = make_req(OP_LOOKUP, 1023, 0, 0);                    rows.push_back(row);
    row.req = make_req(OP_PAGE_IN, 5, 8'h42, 0);                  rows.push_back(row);
    row.req = make_req(OP_PAGE_IN, 512, 8'h80, 64);               rows.push_back(row);
    row.req = make_req(OP_LOOKUP, 512, 0, 0);                     rows.push_back(row);
    row.req = make_req(OP_LOOKUP, 513, 0, 0);                     rows.push_back(row);
    row.req = make_req(OP_EVICT, 0, 0, 2);                        rows.push_back(row);
    row.req = make_req(OP_LOOKUP, 1023, 0, 0);                    rows.push_back(row);
    row.req = make_req(OP_UNDEF, 0, 0, 0);                        rows.push_back(row);
    row.req = make_req(OP_EVICT, 0, 0, 127);                      rows.push_back(row);
    row.req = make_req(OP_PAGE_IN, 341, 8'haa, 85);               rows.push_back(row);
    row.req = make_req(OP_LOOKUP, 341, 8'h55, 42);                rows.push_back(row);

    // synchronous reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      row_typed  = rows[i].typed;
      row_answer = rows[i].answer;
      send_request(rows[i].req);
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 5));
    end
    row_typed = 1'b0;

    // random part: segments of one traffic mix, the first one filling the table
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent == 0) begin
        mix     = MIX_FILL;
        seg_len = 180;
        gappy   = 1'b1;
      end else begin
        mix     = $urandom_range(MIX_FILL, MIX_BLEND);
        seg_len = $urandom_range(30, 180);
        gappy   = ($urandom_range(0, 2) != 0);
      end
      for (int j = 0; j < seg_len && sent < RANDOM_ITEMS; j++) begin
        send_request(draw_request(mix));
        sent++;
        // no idling in the closing stretch
        if (gappy && sent < RANDOM_ITEMS * 17 / 20 && $urandom_range(0, 3) == 0)
          hold_off($urandom_range(1, 5));
      end
    end
    start <= 1'b0;

    // drain outstanding results, then watch for strays
    waited = 0;
    while (due_responses.size() != 0 && waited < 4 * FRAMES) begin
      @(posedge clk);
      waited++;
    end
    repeat (FRAMES + 8) @(posedge clk);

    if (mismatch_total == 0 && due_responses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* page_frame_allocator.f */
rtl/pfa_pkg.sv
rtl/page_frame_allocator.sv
rtl/pfa_checker.sv
dv/page_frame_allocator_tb.sv
